### sv/bcd_pkg.sv
package bcd_pkg;

  parameter int unsigned MAX_DIMENSION = 16384;

  // format codes
  typedef enum logic [1:0] {
    FMT_BC1 = 2'd0,
    FMT_BC2 = 2'd1,
    FMT_BC3 = 2'd2
  } fmt_e;

  // register map, byte address 4*index
  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_UNDO   = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_e;

  typedef struct packed {
    logic [63:0] color_half;
    logic [63:0] alpha_half;
    logic [11:0] block_column;
    logic [11:0] block_row;
  } in_t;

  typedef struct packed {
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_in_block;
  } out_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        undo;
    logic [14:0] width;
    logic [14:0] height;
  } cfg_t;

  // decoded block, ready for the pixel walker
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;        // palette entry, channel r/g/b
    logic                 pal3_opaque;
    logic [7:0][7:0]      apal;       // BC3 alpha palette
    logic [31:0]          idx;
    logic [63:0]          alpha_half;
    logic [13:0]          bx;
    logic [13:0]          by;
    logic [2:0]           ncol;       // in-bounds columns, 0..4
    logic [2:0]           nrow;       // in-bounds rows, 0..4
    logic                 bc2;
    logic                 bc3;
  } blk_t;

  // one pixel before the premultiply undo
  typedef struct packed {
    logic [13:0]     x;
    logic [13:0]     y;
    logic [2:0][7:0] rgb;
    logic [7:0]      a;
    logic            last;
    logic            undo;
  } px_t;

endpackage

### sv/bc1_bc2_bc3_block_decoder.sv
// BC1/BC2/BC3 (S3TC) block decoder.
// Input channel: a transaction is taken at a rising edge with start high and busy low;
//   block_i carries the 64-bit color half, 64-bit alpha half and the block column/row.
// Output channel: each decoded pixel is on result_o for one cycle with result_valid_o
//   high; in-bounds pixels of a block leave in raster order on consecutive cycles,
//   last_in_block marks the final one. Out-of-bounds pixels are dropped.
// Config: APB slave, format at 0x0, undo-premultiply at 0x4, width 0x8, height 0xC.
//   Write only while the block is idle. pready is tied high.
// Path: the first pixel of a block passes 3 block stages, the walker, the pixel register,
//   a 5 stage divider and the output register.
// Throughput: one pixel per cycle while a block is in the walker. A block holds the pixel
//   walker until its last in-bounds pixel (a fully clipped block only as it loads), and the
//   next block loads with that last pixel, so a stream of interior blocks leaves back to back.
//   busy rises once the three block stages are full behind the walker.
// Reset: all valid bits clear, registers return to BC1, no undo, 4x4 surface.
// The receiver cannot stall; the pixel path never stops once a block is in the walker.
module bc1_bc2_bc3_block_decoder #(
  parameter int unsigned MaxDimension = bcd_pkg::MAX_DIMENSION
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // block command
  input  logic          start,
  output logic          busy,
  input  bcd_pkg::in_t  block_i,
  // pixel results
  output logic          result_valid_o,
  output bcd_pkg::out_t result_o,
  // APB config
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import bcd_pkg::*;

  cfg_t  cfg_q;
  reg_e  reg_idx;
  logic  wr_en;

  logic  blk_valid, blk_ready;
  blk_t  blk;
  logic  px_valid;
  px_t   px;

  assign pready  = 1'b1;
  assign reg_idx = reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register file, written in the APB access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= FMT_BC1;
      cfg_q.undo   <= 1'b0;
      cfg_q.width  <= 15'd4;
      cfg_q.height <= 15'd4;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FORMAT: cfg_q.fmt    <= pwdata[1:0];
        REG_UNDO:   cfg_q.undo   <= pwdata[0];
        REG_WIDTH:  cfg_q.width  <= pwdata[14:0];
        REG_HEIGHT: cfg_q.height <= pwdata[14:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT: prdata = {30'd0, cfg_q.fmt};
      REG_UNDO:   prdata = {31'd0, cfg_q.undo};
      REG_WIDTH:  prdata = {17'd0, cfg_q.width};
      REG_HEIGHT: prdata = {17'd0, cfg_q.height};
    endcase
  end

  // per-block front end: palettes and clip extents
  bcd_palette #(
    .MaxDimension(MaxDimension)
  ) u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_i        (block_i),
    .busy_o      (busy),
    .cfg_i       (cfg_q),
    .blk_valid_o (blk_valid),
    .blk_o       (blk),
    .blk_ready_i (blk_ready)
  );

  // one in-bounds pixel per cycle while a block is active
  bcd_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (blk_valid),
    .blk_i       (blk),
    .blk_ready_o (blk_ready),
    .undo_i      (cfg_q.undo),
    .px_valid_o  (px_valid),
    .px_o        (px)
  );

  // c*255/alpha with saturation, pipelined restoring divider
  bcd_unmul u_unmul (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .px_valid_i     (px_valid),
    .px_i           (px),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### sv/bcd_palette.sv
module bcd_palette #(
  parameter int unsigned MaxDimension = bcd_pkg::MAX_DIMENSION
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  bcd_pkg::in_t  in_i,
  output logic          busy_o,
  input  bcd_pkg::cfg_t cfg_i,
  output logic          blk_valid_o,
  output bcd_pkg::blk_t blk_o,
  input  logic          blk_ready_i
);
  import bcd_pkg::*;

  typedef struct packed {
    logic [1:0][2:0][7:0] c;      // expanded endpoints
    logic [2:0][9:0]      s2;     // sum for entry 2
    logic [2:0][9:0]      s3;     // sum for entry 3
    logic                 four;   // four-color palette
    logic [5:0][10:0]     asum;
    logic [7:0]           a0;
    logic [7:0]           a1;
    logic                 amode7;
    logic [31:0]          idx;
    logic [63:0]          alpha_half;
    logic [13:0]          bx;
    logic [13:0]          by;
    logic [2:0]           ncol;
    logic [2:0]           nrow;
    logic                 bc2;
    logic                 bc3;
  } sum_t;

  logic  v1_q, v2_q, v3_q;
  logic  rdy1, rdy2, rdy3;
  in_t   s1_q;
  sum_t  s2_d, s2_q;
  blk_t  s3_d, s3_q;

  function automatic logic [7:0] div3(logic [9:0] x);
    logic [19:0] pr;
    pr = 20'(x) * 20'd683;
    return pr[18:11];
  endfunction

  function automatic logic [7:0] div7(logic [10:0] x);
    logic [22:0] pr;
    pr = 23'(x) * 23'd2341;
    return pr[21:14];
  endfunction

  function automatic logic [7:0] div5(logic [10:0] x);
    logic [22:0] pr;
    pr = 23'(x) * 23'd3277;
    return pr[21:14];
  endfunction

  function automatic logic [2:0][7:0] unpack565(logic [15:0] v);
    logic [2:0][7:0] c;
    c[0] = {v[15:11], v[15:13]};
    c[1] = {v[10:5], v[10:9]};
    c[2] = {v[4:0], v[4:2]};
    return c;
  endfunction

  function automatic logic [2:0] span(logic [16:0] lim, logic [13:0] base);
    logic [16:0] b;
    logic [16:0] dw;
    b  = 17'(base);
    dw = lim - b;
    if (lim <= b) begin
      return 3'd0;
    end else if (dw >= 17'd4) begin
      return 3'd4;
    end
    return dw[2:0];
  endfunction

  assign rdy3   = !v3_q || blk_ready_i;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign busy_o = !rdy1;

  // stage 2: endpoint expansion, interpolation sums, clipping
  always_comb begin
    logic [15:0] v0, v1;
    logic        bc1;
    logic [16:0] wl, hl;
    v0 = s1_q.color_half[15:0];
    v1 = s1_q.color_half[31:16];
    bc1 = (cfg_i.fmt != FMT_BC2) && (cfg_i.fmt != FMT_BC3);
    s2_d = '0;
    s2_d.c[0] = unpack565(v0);
    s2_d.c[1] = unpack565(v1);
    s2_d.four = (v0 > v1) || !bc1;
    for (int k = 0; k < 3; k++) begin
      if (s2_d.four) begin
        s2_d.s2[k] = {1'b0, s2_d.c[0][k], 1'b0} + 10'(s2_d.c[1][k]);
        s2_d.s3[k] = 10'(s2_d.c[0][k]) + {1'b0, s2_d.c[1][k], 1'b0};
      end else begin
        s2_d.s2[k] = 10'(s2_d.c[0][k]) + 10'(s2_d.c[1][k]);
        s2_d.s3[k] = '0;
      end
    end
    s2_d.a0     = s1_q.alpha_half[7:0];
    s2_d.a1     = s1_q.alpha_half[15:8];
    s2_d.amode7 = s2_d.a0 > s2_d.a1;
    for (int k = 0; k < 6; k++) begin
      if (s2_d.amode7) begin
        s2_d.asum[k] = 11'((6 - k) * s2_d.a0 + (1 + k) * s2_d.a1);
      end else if (k < 4) begin
        s2_d.asum[k] = 11'((4 - k) * s2_d.a0 + (1 + k) * s2_d.a1);
      end else begin
        s2_d.asum[k] = '0;
      end
    end
    s2_d.idx        = s1_q.color_half[63:32];
    s2_d.alpha_half = s1_q.alpha_half;
    s2_d.bx         = {s1_q.block_column, 2'b00};
    s2_d.by         = {s1_q.block_row, 2'b00};
    wl = (17'(cfg_i.width) > 17'(MaxDimension)) ? 17'(MaxDimension) : 17'(cfg_i.width);
    hl = (17'(cfg_i.height) > 17'(MaxDimension)) ? 17'(MaxDimension) : 17'(cfg_i.height);
    s2_d.ncol = span(wl, s2_d.bx);
    s2_d.nrow = span(hl, s2_d.by);
    s2_d.bc2  = cfg_i.fmt == FMT_BC2;
    s2_d.bc3  = cfg_i.fmt == FMT_BC3;
  end

  // stage 3: constant divisions
  always_comb begin
    s3_d = '0;
    s3_d.pal[0] = s2_q.c[0];
    s3_d.pal[1] = s2_q.c[1];
    for (int k = 0; k < 3; k++) begin
      s3_d.pal[2][k] = s2_q.four ? div3(s2_q.s2[k]) : s2_q.s2[k][8:1];
      s3_d.pal[3][k] = s2_q.four ? div3(s2_q.s3[k]) : 8'd0;
    end
    s3_d.pal3_opaque = s2_q.four;
    s3_d.apal[0] = s2_q.a0;
    s3_d.apal[1] = s2_q.a1;
    for (int k = 0; k < 6; k++) begin
      if (s2_q.amode7) begin
        s3_d.apal[2 + k] = div7(s2_q.asum[k]);
      end else if (k < 4) begin
        s3_d.apal[2 + k] = div5(s2_q.asum[k]);
      end else begin
        s3_d.apal[2 + k] = (k == 4) ? 8'd0 : 8'd255;
      end
    end
    s3_d.idx        = s2_q.idx;
    s3_d.alpha_half = s2_q.alpha_half;
    s3_d.bx         = s2_q.bx;
    s3_d.by         = s2_q.by;
    s3_d.ncol       = s2_q.ncol;
    s3_d.nrow       = s2_q.nrow;
    s3_d.bc2        = s2_q.bc2;
    s3_d.bc3        = s2_q.bc3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= in_i;
    if (rdy2 && v1_q) s2_q <= s2_d;
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign blk_valid_o = v3_q;
  assign blk_o       = s3_q;

endmodule

### sv/bcd_walker.sv
module bcd_walker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          blk_valid_i,
  input  bcd_pkg::blk_t blk_i,
  output logic          blk_ready_o,
  input  logic          undo_i,
  output logic          px_valid_o,
  output bcd_pkg::px_t  px_o
);
  import bcd_pkg::*;

  blk_t       blk_q;
  logic       active_q;
  logic [1:0] col_q, row_q;
  logic       col_end, row_end, last;
  logic       load;
  px_t        px_d, px_q;
  logic       px_valid_q;

  assign col_end     = {1'b0, col_q} == (blk_q.ncol - 3'd1);
  assign row_end     = {1'b0, row_q} == (blk_q.nrow - 3'd1);
  assign last        = col_end && row_end;
  assign blk_ready_o = !active_q || last;
  assign load        = blk_valid_i && blk_ready_o;

  always_comb begin
    logic [3:0] p;
    logic [1:0] ci;
    logic [5:0] coff;
    logic [5:0] boff;
    logic [5:0] aoff;
    logic [3:0] a4;
    logic [2:0] ai;
    p    = {row_q, col_q};
    coff = {1'b0, p, 1'b0};
    boff = {p, 2'b00};
    aoff = 6'd16 + {2'b00, p} + {1'b0, p, 1'b0};
    ci   = blk_q.idx[coff[4:0] +: 2];
    a4   = blk_q.alpha_half[boff +: 4];
    ai   = blk_q.alpha_half[aoff +: 3];
    px_d.x    = {blk_q.bx[13:2], col_q};
    px_d.y    = {blk_q.by[13:2], row_q};
    px_d.rgb  = blk_q.pal[ci];
    px_d.last = last;
    px_d.undo = undo_i;
    if (blk_q.bc2) begin
      px_d.a = {a4, a4};
    end else if (blk_q.bc3) begin
      px_d.a = blk_q.apal[ai];
    end else begin
      px_d.a = (ci == 2'd3 && !blk_q.pal3_opaque) ? 8'd0 : 8'd255;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      px_valid_q <= 1'b0;
    end else begin
      px_valid_q <= active_q;
      if (load) begin
        active_q <= (blk_i.ncol != 3'd0) && (blk_i.nrow != 3'd0);
        col_q    <= '0;
        row_q    <= '0;
      end else if (active_q) begin
        if (last) begin
          active_q <= 1'b0;
        end else if (col_end) begin
          col_q <= '0;
          row_q <= row_q + 2'd1;
        end else begin
          col_q <= col_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) blk_q <= blk_i;
    if (active_q) px_q <= px_d;
  end

  assign px_valid_o = px_valid_q;
  assign px_o       = px_q;

endmodule

### sv/bcd_unmul.sv
module bcd_unmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          px_valid_i,
  input  bcd_pkg::px_t  px_i,
  output logic          result_valid_o,
  output bcd_pkg::out_t result_o
);
  import bcd_pkg::*;

  localparam int DivStages = 4;   // two quotient bits per stage

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] rem;
    logic [7:0] lo;
    logic [7:0] q;
    logic       ovf;
  } div_t;

  typedef struct packed {
    logic [13:0]     x;
    logic [13:0]     y;
    logic [7:0]      a;
    logic            last;
    logic            bypass;
    div_t [2:0]      ch;
  } ust_t;

  ust_t           st_q [DivStages + 1];
  logic [DivStages:0] vld_q;
  out_t           res_q;
  logic           res_valid_q;

  function automatic ust_t ust_init(px_t px);
    ust_t        s;
    logic [15:0] n;
    s        = '0;
    s.x      = px.x;
    s.y      = px.y;
    s.a      = px.a;
    s.last   = px.last;
    s.bypass = !px.undo || (px.a == 8'd0);
    for (int k = 0; k < 3; k++) begin
      n = {px.rgb[k], 8'd0} - {8'd0, px.rgb[k]};   // c*255
      s.ch[k].c   = px.rgb[k];
      s.ch[k].ovf = n >= {px.a, 8'd0};
      s.ch[k].rem = n[15:8];
      s.ch[k].lo  = n[7:0];
      s.ch[k].q   = '0;
    end
    return s;
  endfunction

  function automatic ust_t ust_step(ust_t s);
    ust_t       r;
    logic [8:0] t;
    r = s;
    for (int k = 0; k < 3; k++) begin
      for (int b = 0; b < 2; b++) begin
        t = {r.ch[k].rem, r.ch[k].lo[7]};
        r.ch[k].lo = {r.ch[k].lo[6:0], 1'b0};
        if (t >= {1'b0, r.a}) begin
          r.ch[k].rem = 8'(t - {1'b0, r.a});
          r.ch[k].q   = {r.ch[k].q[6:0], 1'b1};
        end else begin
          r.ch[k].rem = t[7:0];
          r.ch[k].q   = {r.ch[k].q[6:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] pick(div_t d, logic bypass);
    if (bypass) return d.c;
    if (d.ovf) return 8'd255;
    return d.q;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      vld_q       <= {vld_q[DivStages-1:0], px_valid_i};
      res_valid_q <= vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= ust_init(px_i);
    for (int k = 1; k <= DivStages; k++) begin
      st_q[k] <= ust_step(st_q[k-1]);
    end
    res_q.pixel_x       <= st_q[DivStages].x;
    res_q.pixel_y       <= st_q[DivStages].y;
    res_q.red           <= pick(st_q[DivStages].ch[0], st_q[DivStages].bypass);
    res_q.green         <= pick(st_q[DivStages].ch[1], st_q[DivStages].bypass);
    res_q.blue          <= pick(st_q[DivStages].ch[2], st_q[DivStages].bypass);
    res_q.alpha         <= st_q[DivStages].a;
    res_q.last_in_block <= st_q[DivStages].last;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### sv/bcd_checker.sv
module bcd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          busy,
  input logic          result_valid_o,
  input bcd_pkg::out_t result_o
);
  import bcd_pkg::*;

  // pipeline is empty while in reset
  a_rst_quiet: assert property (@(posedge clk_i)
    (!rst_ni ##1 !rst_ni) |-> (!result_valid_o && !busy))
    else $error("output or busy active during reset");

  // pixels of one block leave back to back
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_in_block) |=> result_valid_o)
    else $error("gap inside a block");

  // raster order inside a block
  a_raster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last_in_block) |=>
      ((result_o.pixel_y == $past(result_o.pixel_y) &&
        result_o.pixel_x == $past(result_o.pixel_x) + 14'd1) ||
       (result_o.pixel_y == $past(result_o.pixel_y) + 14'd1)))
    else $error("pixel order broken inside a block");

endmodule

bind bc1_bc2_bc3_block_decoder bcd_checker u_bcd_checker (.*);

### dv/bc1_bc2_bc3_block_decoder_test.sv
module bc1_bc2_bc3_block_decoder_test;
  import bcd_pkg::*;

  // unused format code, must decode as BC1
  localparam logic [1:0] FMT_SPARE = 2'd3;
  // cycles left after the last pixel before the block counts as idle:
  // the pixel pipeline plus fully clipped blocks still queued behind it
  localparam int unsigned IDLE_CYCLES = 40;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned BLOCKS_PER_PHASE = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         block_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the register file, used by the pixel predictor
  logic [1:0]  cfg_fmt = FMT_BC1;
  logic        cfg_undo = 1'b0;
  logic [14:0] cfg_width = 15'd4;
  logic [14:0] cfg_height = 15'd4;

  out_t        expected_pixels[$];
  int unsigned errors = 0;
  int unsigned blocks_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned burst_left = 0;

  bc1_bc2_bc3_block_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .block_i       (block_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // Undo premultiplied alpha on one channel; alpha zero leaves it alone.
  function automatic int unsigned unpremultiply(input int unsigned c, input int unsigned a);
    int unsigned q;
    if (a == 0) return c;
    q = (c * 255) / a;
    return (q > 255) ? 255 : q;
  endfunction

  // Expand an RGB565 endpoint into three 8-bit channels.
  function automatic void expand_565(input logic [15:0] v, output int unsigned rgb[3]);
    rgb[0] = 32'({v[15:11], v[15:13]});
    rgb[1] = 32'({v[10:5], v[10:9]});
    rgb[2] = 32'({v[4:0], v[4:2]});
  endfunction

  // Decode one block with the shadow registers and queue its in-bounds pixels.
  function automatic void decode_block_pixels(input in_t blk);
    int unsigned pal[4][4];
    int unsigned apal[8];
    int unsigned c0[3];
    int unsigned c1[3];
    int unsigned w, h, bx, by, x, y, sel, a, n;
    logic [15:0] v0, v1;
    logic        four_color;
    out_t        px[16];

    v0 = blk.color_half[15:0];
    v1 = blk.color_half[31:16];
    w = (cfg_width > MAX_DIMENSION) ? MAX_DIMENSION : cfg_width;
    h = (cfg_height > MAX_DIMENSION) ? MAX_DIMENSION : cfg_height;
    bx = blk.block_column * 4;
    by = blk.block_row * 4;
    n = 0;

    expand_565(v0, c0);
    expand_565(v1, c1);
    // BC2/BC3 always use four colors; BC1 (and the spare code) switch on v0 > v1
    four_color = (v0 > v1) || (cfg_fmt == FMT_BC2) || (cfg_fmt == FMT_BC3);
    for (int k = 0; k < 3; k++) begin
      pal[0][k] = c0[k];
      pal[1][k] = c1[k];
      if (four_color) begin
        pal[2][k] = (2 * c0[k] + c1[k]) / 3;
        pal[3][k] = (c0[k] + 2 * c1[k]) / 3;
      end else begin
        pal[2][k] = (c0[k] + c1[k]) / 2;
        pal[3][k] = 0;
      end
    end
    pal[0][3] = 255;
    pal[1][3] = 255;
    pal[2][3] = 255;
    pal[3][3] = four_color ? 255 : 0;

    // BC3 alpha ramp: two endpoints plus 6 interpolated levels, or 4 plus 0 and 255
    apal[0] = 32'(blk.alpha_half[7:0]);
    apal[1] = 32'(blk.alpha_half[15:8]);
    if (apal[0] > apal[1]) begin
      for (int k = 0; k < 6; k++)
        apal[2 + k] = ((6 - k) * apal[0] + (1 + k) * apal[1]) / 7;
    end else begin
      for (int k = 0; k < 4; k++)
        apal[2 + k] = ((4 - k) * apal[0] + (1 + k) * apal[1]) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end

    for (int p = 0; p < 16; p++) begin
      x = bx + (p % 4);
      y = by + (p / 4);
      if (x < w && y < h) begin
        sel = 32'(blk.color_half[32 + 2 * p +: 2]);
        a = pal[sel][3];
        if (cfg_fmt == FMT_BC2)
          a = blk.alpha_half[4 * p +: 4] * 17;
        else if (cfg_fmt == FMT_BC3)
          a = apal[blk.alpha_half[16 + 3 * p +: 3]];
        px[n].pixel_x = 14'(x);
        px[n].pixel_y = 14'(y);
        px[n].red = 8'(cfg_undo ? unpremultiply(pal[sel][0], a) : pal[sel][0]);
        px[n].green = 8'(cfg_undo ? unpremultiply(pal[sel][1], a) : pal[sel][1]);
        px[n].blue = 8'(cfg_undo ? unpremultiply(pal[sel][2], a) : pal[sel][2]);
        px[n].alpha = 8'(a);
        px[n].last_in_block = 1'b0;
        n++;
      end
    end
    if (n > 0) px[n - 1].last_in_block = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(px[i]);
  endfunction

  // Sender pacing: bursts of random length, random gaps in between.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // long stretches without idling now and then
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // One block transaction: hold start until busy is low at a rising edge.
  task automatic send_block(input in_t blk);
    logic taken;
    start <= 1'b1;
    block_i <= blk;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    decode_block_pixels(blk);
    blocks_sent++;
    pace_sender();
  endtask

  // Wait until every expected pixel has left and the pipeline has emptied.
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(input reg_e r, input logic [31:0] value, input logic [31:0] mask);
    logic        rdy;
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      rd = prdata;
      @(posedge clk_i);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (rd !== (value & mask))
      report_mismatch($sformatf("register %s read 0x%0h, wrote 0x%0h", r.name(), rd,
                                value & mask));
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic undo,
                            input logic [14:0] w, input logic [14:0] h);
    wait_idle();
    write_reg(REG_FORMAT, 32'(fmt), 32'h3);
    write_reg(REG_UNDO, 32'(undo), 32'h1);
    write_reg(REG_WIDTH, 32'(w), 32'h7FFF);
    write_reg(REG_HEIGHT, 32'(h), 32'h7FFF);
    cfg_fmt = fmt;
    cfg_undo = undo;
    cfg_width = w;
    cfg_height = h;
  endtask

  function automatic in_t make_block(input logic [63:0] color, input logic [63:0] alpha,
                                     input logic [11:0] col, input logic [11:0] row);
    in_t blk;
    blk.color_half = color;
    blk.alpha_half = alpha;
    blk.block_column = col;
    blk.block_row = row;
    return blk;
  endfunction

  // Random block, mostly landing on or just past the visible surface.
  function automatic in_t random_block();
    in_t         blk;
    int unsigned span_x, span_y;
    span_x = (((cfg_width > MAX_DIMENSION) ? MAX_DIMENSION : cfg_width) + 3) / 4;
    span_y = (((cfg_height > MAX_DIMENSION) ? MAX_DIMENSION : cfg_height) + 3) / 4;
    if (span_x > 4095) span_x = 4095;
    if (span_y > 4095) span_y = 4095;
    blk.color_half = {$urandom, $urandom};
    blk.alpha_half = {$urandom, $urandom};
    // equal endpoints now and then
    if ($urandom_range(0, 19) == 0) blk.color_half[31:16] = blk.color_half[15:0];
    blk.block_column = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(0, span_x));
    blk.block_row = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                                : 12'($urandom_range(0, span_y));
    return blk;
  endfunction

  function automatic logic [14:0] random_dimension();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 15'($urandom_range(1, 40));
      5, 6:          return 15'($urandom_range(41, 300));
      7:             return 15'h7FFF;
      8:             return 15'(MAX_DIMENSION);
      default:       return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // Checker: every strobed pixel against the oldest expectation.
  always @(negedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel at (%0d,%0d)", result_o.pixel_x,
                                  result_o.pixel_y));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (result_o.pixel_x !== want.pixel_x)
          report_mismatch($sformatf("pixel_x %0d, expected %0d", result_o.pixel_x,
                                    want.pixel_x));
        if (result_o.pixel_y !== want.pixel_y)
          report_mismatch($sformatf("pixel_y %0d, expected %0d", result_o.pixel_y,
                                    want.pixel_y));
        if (result_o.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d at (%0d,%0d)", result_o.red,
                                    want.red, want.pixel_x, want.pixel_y));
        if (result_o.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d at (%0d,%0d)", result_o.green,
                                    want.green, want.pixel_x, want.pixel_y));
        if (result_o.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d at (%0d,%0d)", result_o.blue,
                                    want.blue, want.pixel_x, want.pixel_y));
        if (result_o.alpha !== want.alpha)
          report_mismatch($sformatf("alpha %0d, expected %0d at (%0d,%0d)", result_o.alpha,
                                    want.alpha, want.pixel_x, want.pixel_y));
        if (result_o.last_in_block !== want.last_in_block)
          report_mismatch($sformatf("last_in_block %0b, expected %0b at (%0d,%0d)",
                                    result_o.last_in_block, want.last_in_block,
                                    want.pixel_x, want.pixel_y));
      end
    end
  end

  // Color palettes: four-color, three-color plus transparent, equal endpoints.
  task automatic test_bc1_palette();
    set_config(FMT_BC1, 1'b0, 15'd4, 15'd4);
    send_block(make_block(64'h0, 64'h0, 12'd0, 12'd0));
    send_block(make_block('1, '1, 12'd0, 12'd0));
    send_block(make_block(64'hE4E4E4E4_001FF800, 64'h0, 12'd0, 12'd0));
    send_block(make_block(64'hE4E4E4E4_F800001F, 64'h0, 12'd0, 12'd0));
    send_block(make_block(64'h1B1B1B1B_07E007E0, 64'h0, 12'd0, 12'd0));
    // spare format code behaves as BC1, alpha half ignored
    set_config(FMT_SPARE, 1'b0, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_F800001F, '1, 12'd0, 12'd0));
  endtask

  // Explicit 4-bit alpha; endpoint order must not select three-color mode.
  task automatic test_bc2_alpha();
    set_config(FMT_BC2, 1'b0, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_F800001F, 64'hFEDCBA98_76543210, 12'd0, 12'd0));
    send_block(make_block(64'h1B1B1B1B_07E0F81F, 64'h0, 12'd0, 12'd0));
    send_block(make_block('1, '1, 12'd0, 12'd0));
  endtask

  // Interpolated alpha: both ramp shapes, every 3-bit index.
  task automatic test_bc3_alpha();
    set_config(FMT_BC3, 1'b0, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_F800001F, {48'hFAC688FAC688, 8'h10, 8'hF0},
                          12'd0, 12'd0));
    send_block(make_block(64'hE4E4E4E4_001FF800, {48'hFAC688FAC688, 8'hF0, 8'h10},
                          12'd0, 12'd0));
    send_block(make_block(64'h1B1B1B1B_FFFF0000, 64'h0, 12'd0, 12'd0));
    send_block(make_block('1, '1, 12'd0, 12'd0));
  endtask

  // Premultiply undo: saturation, alpha zero left alone, BC1 unaffected.
  task automatic test_undo_premultiply();
    set_config(FMT_BC2, 1'b1, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_FFFF7BEF, 64'h10F0_10F0_1F01_F010, 12'd0, 12'd0));
    set_config(FMT_BC3, 1'b1, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_F81F07FF, {48'hFAC688FAC688, 8'h00, 8'h00},
                          12'd0, 12'd0));
    set_config(FMT_BC1, 1'b1, 15'd4, 15'd4);
    send_block(make_block(64'hE4E4E4E4_FFFF0841, 64'h0, 12'd0, 12'd0));
  endtask

  // Edge clipping, blocks wholly outside, zero and oversized dimensions.
  task automatic test_clipping();
    set_config(FMT_BC1, 1'b0, 15'd6, 15'd5);
    send_block(make_block(64'h5A5A5A5A_F800001F, 64'h0, 12'd0, 12'd0));
    send_block(make_block(64'hA5A5A5A5_F800001F, 64'h0, 12'd1, 12'd1));
    send_block(make_block(64'hE4E4E4E4_F800001F, 64'h0, 12'd2, 12'd0));
    send_block(make_block(64'h1B1B1B1B_001FF800, 64'h0, 12'd1, 12'd0));
    set_config(FMT_BC1, 1'b0, 15'd0, 15'd4);
    send_block(make_block(64'hE4E4E4E4_F800001F, 64'h0, 12'd0, 12'd0));
    set_config(FMT_BC3, 1'b0, 15'h7FFF, 15'h7FFF);
    send_block(make_block(64'hE4E4E4E4_F800001F, '1, 12'hFFF, 12'hFFF));
    set_config(FMT_BC2, 1'b1, 15'(MAX_DIMENSION), 15'd1);
    send_block(make_block(64'h1B1B1B1B_07E0F800, 64'h0123456789ABCDEF, 12'hFFF, 12'd0));
  endtask

  // Random phases, each under its own register setting.
  task automatic test_random_blocks();
    logic [1:0] fmt;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fmt = 2'($urandom_range(0, 3));
      set_config(fmt, 1'($urandom_range(0, 1)), random_dimension(), random_dimension());
      for (int i = 0; i < BLOCKS_PER_PHASE; i++) send_block(random_block());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bc1_palette();
    test_bc2_alpha();
    test_bc3_alpha();
    test_undo_premultiply();
    test_clipping();
    test_random_blocks();

    // drain: every pixel accounted for, then the pipeline latency
    wait_idle();
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));

    $display("Sent %0d blocks through BC1, BC2, BC3 and the spare format code,", blocks_sent);
    $display("with undo on and off and clipped surfaces; %0d pixels compared.",
             pixels_checked);
    if (errors == 0)
      $display("bc1_bc2_bc3_block_decoder_test passed");
    else
      $display("bc1_bc2_bc3_block_decoder_test failed");
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TIMEOUT: run did not finish");
    $display("bc1_bc2_bc3_block_decoder_test failed");
    $finish;
  end

endmodule
